// File: src/glbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glbp_pkg
// Shared constants and types for the graded block pixelation block.
// ----------------------------------------------------------------------------
package glbp_pkg;

	// Line store depth by default, in pixels
	localparam int DEFAULT_MAX_WIDTH = 2048;

	// Field widths fixed by the interface
	localparam int CHAN_W       = 8;
	localparam int PIX_W        = 3 * CHAN_W;
	localparam int IMG_WIDTH_W  = 12;
	localparam int IMG_HEIGHT_W = 13;
	localparam int ROW_W        = 12;
	localparam int CFG_INDEX_W  = 2;
	localparam int CFG_DATA_W   = 13;

	// Largest frame height in rows
	localparam logic [IMG_HEIGHT_W-1:0] ROW_LIMIT = 13'd4096;

	// Reset values of the configuration registers
	localparam logic [IMG_WIDTH_W-1:0]  IMG_WIDTH_RST  = 12'd640;
	localparam logic [IMG_HEIGHT_W-1:0] IMG_HEIGHT_RST = 13'd480;

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

	// Block size of a width quarter
	typedef enum logic [1:0] {
		ZONE_B1 = 2'd0,
		ZONE_B2 = 2'd1,
		ZONE_B4 = 2'd2,
		ZONE_B8 = 2'd3
	} zone_t;

	// Per-pixel decisions from the raster scanner
	typedef struct packed {
		logic hold_load;   // load the hold register with this pixel
		logic src_row;     // block source row: write the line store
		logic frame_last;  // last pixel of the frame
	} scan_ctl_t;

endpackage

// File: src/glbp_line_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glbp_line_store
// Single-port line memory, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module glbp_line_store #(
	parameter int DEPTH = glbp_pkg::DEFAULT_MAX_WIDTH,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic                      we,
	input  logic [AW-1:0]             addr,
	input  logic [glbp_pkg::PIX_W-1:0] wdata,
	output logic [glbp_pkg::PIX_W-1:0] rdata
);

	logic [glbp_pkg::PIX_W-1:0] mem [DEPTH];

	// Write or read; read data holds when no read is issued
	always_ff @(posedge clk) begin
		if (en && we) begin
			mem[addr] <= wdata;
		end
		if (en && !we) begin
			rdata <= mem[addr];
		end
	end

endmodule

// File: src/glbp_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glbp_scan
// Raster column and row counters with width-quarter block size decision.
// ----------------------------------------------------------------------------
module glbp_scan #(
	parameter int MAX_WIDTH = glbp_pkg::DEFAULT_MAX_WIDTH,
	parameter int CW        = $clog2(MAX_WIDTH)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             advance,
	input  logic [glbp_pkg::IMG_WIDTH_W-1:0]  image_width,
	input  logic [glbp_pkg::IMG_HEIGHT_W-1:0] image_height,
	output logic [CW-1:0]                    col,
	output glbp_pkg::scan_ctl_t              ctl
);

	localparam int EW   = CW + 1;
	localparam int TW   = CW + 3;
	localparam int CMPW = (TW > glbp_pkg::IMG_WIDTH_W) ? TW : glbp_pkg::IMG_WIDTH_W;
	localparam logic [CMPW-1:0] MAXW_C = CMPW'(MAX_WIDTH);

	logic [CW-1:0]                    col_q;
	logic [glbp_pkg::ROW_W-1:0]        row_q;
	logic [CMPW-1:0]                  w_raw;
	logic [CMPW-1:0]                  w_clip;
	logic [EW-1:0]                    w_eff;
	logic [glbp_pkg::IMG_HEIGHT_W-1:0] h_eff;
	logic [TW-1:0]                    quad;
	logic [TW-1:0]                    w1;
	logic [TW-1:0]                    w2;
	logic [TW-1:0]                    w3;
	glbp_pkg::zone_t                  zone;
	logic [2:0]                       mask;
	logic                             last_col;
	logic                             last_row;

	// Limit width and height to their legal ranges
	always_comb begin
		w_raw = CMPW'(image_width);
		if (w_raw == '0) begin
			w_clip = CMPW'(1);
		end else if (w_raw > MAXW_C) begin
			w_clip = MAXW_C;
		end else begin
			w_clip = w_raw;
		end
		w_eff = w_clip[EW-1:0];
		if (image_height == '0) begin
			h_eff = glbp_pkg::IMG_HEIGHT_W'(1);
		end else if (image_height > glbp_pkg::ROW_LIMIT) begin
			h_eff = glbp_pkg::ROW_LIMIT;
		end else begin
			h_eff = image_height;
		end
	end

	// Pick the block size from the width quarter of this column
	always_comb begin
		quad = {1'b0, col_q, 2'b00};
		w1   = TW'(w_eff);
		w2   = w1 << 1;
		w3   = w1 + w2;
		if (quad < w1) begin
			zone = glbp_pkg::ZONE_B1;
		end else if (quad < w2) begin
			zone = glbp_pkg::ZONE_B2;
		end else if (quad < w3) begin
			zone = glbp_pkg::ZONE_B4;
		end else begin
			zone = glbp_pkg::ZONE_B8;
		end
		case (zone)
			glbp_pkg::ZONE_B1: mask = 3'b000;
			glbp_pkg::ZONE_B2: mask = 3'b001;
			glbp_pkg::ZONE_B4: mask = 3'b011;
			glbp_pkg::ZONE_B8: mask = 3'b111;
			default:           mask = 3'b000;
		endcase
	end

	// End of row and end of frame
	assign last_col = (EW'({1'b0, col_q} + EW'(1)) >= w_eff);
	assign last_row = (glbp_pkg::IMG_HEIGHT_W'({1'b0, row_q} + 13'd1) >= h_eff);

	assign col            = col_q;
	assign ctl.hold_load  = ((col_q[2:0] & mask) == 3'b000);
	assign ctl.src_row    = ((row_q[2:0] & mask) == 3'b000);
	assign ctl.frame_last = last_col && last_row;

	// Advance the raster position on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + glbp_pkg::ROW_W'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

endmodule

// File: src/graded_block_pixelation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graded_block_pixelation
// Mosaic filter on a raster BGR stream with block size graded by width quarter.
// ----------------------------------------------------------------------------
// One pixel word in, one word out, at one word per clock; the rate is set by the
// single port of the line store, which takes exactly one access per pixel (a
// write on block source rows, a read elsewhere), so back-to-back words never
// wait on it. The output stage holds one word; input ready drops only while that
// word is stalled. Columns in the first width quarter pass unchanged, the
// second, third and fourth quarters are replicated in 2x2, 4x4 and 8x8 blocks.
// Frame geometry comes from image_width (register 0) and image_height (register
// 1), written by the user over the cfg port only while the stream is idle, which
// the block does not enforce. frame_end marks the last pixel of a frame. The
// line store needs no clearing: row 0 writes every entry before any read.
// ----------------------------------------------------------------------------
module graded_block_pixelation #(
	parameter int MAX_WIDTH = glbp_pkg::DEFAULT_MAX_WIDTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [glbp_pkg::CHAN_W-1:0]       blue_in,
	input  logic [glbp_pkg::CHAN_W-1:0]       green_in,
	input  logic [glbp_pkg::CHAN_W-1:0]       red_in,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [glbp_pkg::CHAN_W-1:0]       blue_out,
	output logic [glbp_pkg::CHAN_W-1:0]       green_out,
	output logic [glbp_pkg::CHAN_W-1:0]       red_out,
	output logic                             frame_end,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [glbp_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [glbp_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);

	logic [glbp_pkg::IMG_WIDTH_W-1:0]  image_width_q;
	logic [glbp_pkg::IMG_HEIGHT_W-1:0] image_height_q;
	logic                             accept;
	logic [CW-1:0]                    col;
	glbp_pkg::scan_ctl_t              ctl;
	logic [glbp_pkg::PIX_W-1:0]        pix_in;
	logic [glbp_pkg::PIX_W-1:0]        held_q;
	logic [glbp_pkg::PIX_W-1:0]        held_next;
	logic [glbp_pkg::PIX_W-1:0]        rd_data;
	logic [glbp_pkg::PIX_W-1:0]        res;
	logic                             valid_s1;
	logic                             src_s1;
	logic                             last_s1;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= glbp_pkg::IMG_WIDTH_RST;
			image_height_q <= glbp_pkg::IMG_HEIGHT_RST;
		end else if (cfg_valid) begin
			if (cfg_index == glbp_pkg::REG_IMAGE_WIDTH) begin
				image_width_q <= cfg_data[glbp_pkg::IMG_WIDTH_W-1:0];
			end
			if (cfg_index == glbp_pkg::REG_IMAGE_HEIGHT) begin
				image_height_q <= cfg_data;
			end
		end
	end

	// Accept a word whenever the output stage is free or draining
	assign in_ready = !valid_s1 || out_ready;
	assign accept   = in_valid && in_ready;

	glbp_scan #(
		.MAX_WIDTH(MAX_WIDTH),
		.CW       (CW)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (accept),
		.image_width (image_width_q),
		.image_height(image_height_q),
		.col         (col),
		.ctl         (ctl)
	);

	// Hold register repeats a block source pixel along the row
	assign pix_in    = {red_in, green_in, blue_in};
	assign held_next = ctl.hold_load ? pix_in : held_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (accept) begin
			held_q <= held_next;
		end
	end

	// Line store repeats it down the rows
	glbp_line_store #(
		.DEPTH(MAX_WIDTH),
		.AW   (CW)
	) u_line (
		.clk  (clk),
		.en   (accept),
		.we   (ctl.src_row),
		.addr (col),
		.wdata(held_next),
		.rdata(rd_data)
	);

	// Output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			src_s1  <= ctl.src_row;
			last_s1 <= ctl.frame_last;
		end
	end

	// Source rows show the hold register, others the stored value
	assign res       = src_s1 ? held_q : rd_data;
	assign out_valid = valid_s1;
	assign blue_out  = res[glbp_pkg::CHAN_W-1:0];
	assign green_out = res[2*glbp_pkg::CHAN_W-1:glbp_pkg::CHAN_W];
	assign red_out   = res[3*glbp_pkg::CHAN_W-1:2*glbp_pkg::CHAN_W];
	assign frame_end = last_s1;

endmodule

// File: src/glbp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glbp_checker
// Port-level checks of the pixelation stream, bound to the top level.
// ----------------------------------------------------------------------------
module glbp_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [glbp_pkg::CHAN_W-1:0] blue_out,
	input  logic [glbp_pkg::CHAN_W-1:0] green_out,
	input  logic [glbp_pkg::CHAN_W-1:0] red_out,
	input  logic                        frame_end
);

	// Every accepted word shows up at the output in the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted word produced no output word");

	// No word is taken while the output word is stalled
	a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input accepted while output stalled");

	// An empty output stage always takes input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output stage");

	// A stalled output word stays and holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(blue_out)
			&& $stable(green_out) && $stable(red_out) && $stable(frame_end))
		else $error("stalled output word changed");

endmodule

bind graded_block_pixelation glbp_checker u_glbp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.blue_out (blue_out),
	.green_out(green_out),
	.red_out  (red_out),
	.frame_end(frame_end)
);
